// ===== rtl/core/kec_pkg.sv =====
// shared types and constants for the key event classifier
`timescale 1ns / 1ps
`default_nettype none

package kec_pkg;

  // event codes carried in the state store and in each result word
  typedef enum logic [2:0] {
    EV_NONE    = 3'd0,
    EV_DOWN    = 3'd1,
    EV_PRESSED = 3'd2,
    EV_UP      = 3'd3,
    EV_MULTI   = 3'd4
  } event_t;

  // bit of the raw key byte that marks a pressed key
  localparam int unsigned PRESS_BIT = 7;

  // reset value of the double click window
  localparam logic [31:0] WINDOW_RESET = 32'd250;

  // control sequencer, one-hot
  typedef enum logic [1:0] {
    SEQ_CLEAR = 2'b01,
    SEQ_RUN   = 2'b10
  } seq_t;

endpackage

`default_nettype wire

// ===== rtl/core/key_event_classifier.sv =====
// top level of the key event classifier: per key press, hold and multi click tracking
`timescale 1ns / 1ps
`default_nettype none

// path: a sample word is read from the key store into stage 1, then moves into the result
//   register; a result stall holds it in stage 1, and sample_stall rises while it waits
// throughput: one sample word per cycle unless stalled, set by the single read-modify-write
//   of the key store (registered read, write back from stage 1, same-key neighbors forwarded)
// reset: synchronous; after rst falls the store is swept to zero, one key a cycle,
//   with sample_stall high until every key is cleared; cfg writes are taken throughout
module key_event_classifier
  import kec_pkg::*;
#(
  parameter int KEY_COUNT  = 256,
  parameter int TIMER_BITS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // configuration: double click window
  input  wire logic        cfg_we,
  input  wire logic [31:0] cfg_wdata,
  // sample channel
  input  wire logic        sample_valid,
  output logic             sample_stall,
  input  wire logic [7:0]  key_number,
  input  wire logic [7:0]  raw_byte,
  input  wire logic [15:0] elapsed_ticks,
  // result channel
  output logic             result_valid,
  input  wire logic        result_stall,
  output logic [7:0]       key_id,
  output logic [2:0]       event_state,
  output logic [31:0]      hold_ticks,
  output logic [31:0]      last_hold_ticks,
  output logic             multi_click_hold
);

  localparam int IDX_BITS = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;
  localparam int TB       = TIMER_BITS;
  // width of the saturating sum: room for timer or tick count plus a carry
  localparam int SW       = ((TB > 16) ? TB : 16) + 1;
  // width used to compare timers with 32-bit quantities
  localparam int CW       = (TB > 32) ? TB : 32;
  localparam logic [TB-1:0]       TMAX      = {TB{1'b1}};
  localparam logic [IDX_BITS-1:0] LAST_IDX  = IDX_BITS'(KEY_COUNT - 1);
  localparam logic [31:0]         KEY_LIMIT = 32'(KEY_COUNT);

  // one store entry per key
  typedef struct packed {
    logic [2:0]    state;
    logic [TB-1:0] gap;
    logic [TB-1:0] hold;
    logic [TB-1:0] prev;
    logic          flag;
  } rec_t;

  // timer add that sticks at the top value
  function automatic logic [TB-1:0] sat_add(input logic [TB-1:0] a, input logic [15:0] b);
    logic [SW-1:0] sum;
    sum = SW'(a) + SW'(b);
    sat_add = (sum >= SW'(TMAX)) ? TMAX : sum[TB-1:0];
  endfunction

  // timer to 32-bit result field, clipped when the timer is wider
  function automatic logic [31:0] to_field(input logic [TB-1:0] v);
    logic [CW-1:0] w;
    w = CW'(v);
    to_field = (w > CW'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : w[31:0];
  endfunction

  // ---------------------------------------------------------------
  // configuration register
  // ---------------------------------------------------------------
  logic [31:0] window;

  always_ff @(posedge clk) begin
    if (rst) begin
      window <= WINDOW_RESET;
    end else if (cfg_we) begin
      window <= cfg_wdata;
    end
  end

  // ---------------------------------------------------------------
  // clearing sequencer
  // ---------------------------------------------------------------
  seq_t                seq;
  logic [IDX_BITS-1:0] clr_idx;
  logic                clearing;

  assign clearing = (seq == SEQ_CLEAR);

  always_ff @(posedge clk) begin
    if (rst) begin
      seq     <= SEQ_CLEAR;
      clr_idx <= '0;
    end else begin
      unique case (seq)
        SEQ_CLEAR: begin
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx == LAST_IDX) begin
            seq <= SEQ_RUN;
          end
        end
        SEQ_RUN: begin
          seq <= SEQ_RUN;
        end
        default: begin
          seq <= SEQ_CLEAR;
        end
      endcase
    end
  end

  // ---------------------------------------------------------------
  // handshake and stage control
  // ---------------------------------------------------------------
  logic s1_valid;
  logic s1_adv;
  logic accept;

  // stage 1 moves into the result register when that register is free or being taken
  assign s1_adv       = s1_valid && (!result_valid || !result_stall);
  assign sample_stall = clearing || (s1_valid && !s1_adv);
  assign accept       = sample_valid && !sample_stall;

  // sample index into the store
  logic [IDX_BITS+7:0]   key_wide;
  logic [IDX_BITS-1:0]   in_idx;
  logic                  in_range;

  assign key_wide = (IDX_BITS + 8)'(key_number);
  assign in_idx   = key_wide[IDX_BITS-1:0];
  assign in_range = {24'd0, key_number} < KEY_LIMIT;

  // ---------------------------------------------------------------
  // stage 1 registers: sample held while its store entry is read
  // ---------------------------------------------------------------
  logic [7:0]          s1_key;
  logic [IDX_BITS-1:0] s1_idx;
  logic                s1_in_range;
  logic [7:0]          s1_raw;
  logic [15:0]         s1_dt;
  logic                fwd_hit;
  rec_t                fwd_rec;
  rec_t                mem_q;
  rec_t                cur;
  rec_t                nxt;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      fwd_hit  <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
        // the word leaving stage 1 now writes the entry this word just read
        fwd_hit  <= s1_adv && s1_in_range && (s1_idx == in_idx);
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_key      <= key_number;
      s1_idx      <= in_idx;
      s1_in_range <= in_range;
      s1_raw      <= raw_byte;
      s1_dt       <= elapsed_ticks;
      fwd_rec     <= nxt;
    end
  end

  // ---------------------------------------------------------------
  // key store: one write port, one registered read port
  // ---------------------------------------------------------------
  rec_t                store [KEY_COUNT];
  logic                wr_en;
  logic [IDX_BITS-1:0] wr_idx;
  rec_t                wr_data;

  always_comb begin
    wr_en   = 1'b0;
    wr_idx  = s1_idx;
    wr_data = nxt;
    if (clearing) begin
      wr_en   = 1'b1;
      wr_idx  = clr_idx;
      wr_data = '0;
    end else if (s1_adv && s1_in_range) begin
      wr_en = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store[wr_idx] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mem_q <= store[in_idx];
    end
  end

  // ---------------------------------------------------------------
  // event update
  // ---------------------------------------------------------------
  logic          pressed;
  logic          released_before;
  logic [TB-1:0] gap_sum;

  assign cur             = fwd_hit ? fwd_rec : mem_q;
  assign pressed         = s1_raw[PRESS_BIT];
  // codes past multi click are treated like a key still held
  assign released_before = (cur.state == EV_NONE) || (cur.state == EV_UP);
  assign gap_sum         = sat_add(cur.gap, s1_dt);

  always_comb begin
    nxt     = cur;
    nxt.gap = gap_sum;
    if (pressed) begin
      if (released_before) begin
        // fresh press: multi click when it follows the last one closely
        if (CW'(gap_sum) <= CW'(window)) begin
          nxt.state = EV_MULTI;
          nxt.flag  = 1'b1;
        end else begin
          nxt.state = EV_DOWN;
          nxt.flag  = 1'b0;
        end
        nxt.gap  = '0;
        nxt.hold = '0;
      end else begin
        nxt.state = EV_PRESSED;
        nxt.hold  = sat_add(cur.hold, s1_dt);
      end
    end else begin
      if (released_before) begin
        nxt.state = EV_NONE;
      end else begin
        // release latches the hold length
        nxt.state = EV_UP;
        nxt.prev  = cur.hold;
        nxt.hold  = '0;
      end
    end
  end

  // ---------------------------------------------------------------
  // result register
  // ---------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (s1_adv) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      key_id <= s1_key;
      if (s1_in_range) begin
        event_state      <= nxt.state;
        hold_ticks       <= to_field(nxt.hold);
        last_hold_ticks  <= to_field(nxt.prev);
        multi_click_hold <= nxt.flag;
      end else begin
        // key outside the store: only the key number is reported
        event_state      <= EV_NONE;
        hold_ticks       <= '0;
        last_hold_ticks  <= '0;
        multi_click_hold <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------
  a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> sample_stall)
    else $error("sample accepted during store clearing");

  a_stage_holds: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_adv) |=> (s1_valid && $stable(s1_key) && $stable(s1_dt)))
    else $error("stage 1 word lost while stalled");

  a_fresh_press_hold_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && (event_state == EV_DOWN || event_state == EV_MULTI))
      |-> (hold_ticks == 32'd0))
    else $error("fresh press with nonzero hold");

  a_multi_flag: assert property (@(posedge clk) disable iff (rst)
    (result_valid && event_state == EV_MULTI) |-> multi_click_hold)
    else $error("multi click without its flag");

  a_release_clears_hold: assert property (@(posedge clk) disable iff (rst)
    (result_valid && event_state == EV_UP) |-> (hold_ticks == 32'd0))
    else $error("release left a hold count");

endmodule

`default_nettype wire

// ===== sim/tb_key_event_classifier.sv =====
// testbench for key_event_classifier: queued random and directed samples checked against a predictor
`timescale 1ns / 1ps

module tb_key_event_classifier;
  import kec_pkg::*;

  localparam int unsigned RUN_LIMIT = 4_000_000;  // cycles before the run is called hung
  localparam int unsigned SETTLE_CYCLES = 4;      // extra wait after the last result came back
  localparam int unsigned LONG_HOLD_SAMPLES = 200; // hold count well past 16 bits
  localparam int unsigned PRESSURE_AT = 400;      // words checked before the long receiver hold
  localparam int unsigned PRESSURE_CYCLES = 300;

  typedef struct packed {
    logic [7:0]  key;
    logic [7:0]  raw;
    logic [15:0] dt;
  } key_sample_t;

  typedef struct packed {
    logic [7:0]  key_id;
    event_t      ev;
    logic [31:0] hold;
    logic [31:0] last_hold;
    logic        multi;
  } key_result_t;

  // clock and reset
  logic clk = 1'b0;
  logic rst = 1'b1;
  always #10 clk = ~clk;

  // block inputs, all known from time zero
  logic        cfg_we = 1'b0;
  logic [31:0] cfg_wdata = '0;
  logic        sample_valid = 1'b0;
  logic [7:0]  key_number = '0;
  logic [7:0]  raw_byte = '0;
  logic [15:0] elapsed_ticks = '0;
  logic        result_stall = 1'b1;

  // block outputs
  logic        sample_stall;
  logic        result_valid;
  logic [7:0]  key_id;
  logic [2:0]  event_state;
  logic [31:0] hold_ticks;
  logic [31:0] last_hold_ticks;
  logic        multi_click_hold;

  key_event_classifier dut (
    .clk              (clk),
    .rst              (rst),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .sample_valid     (sample_valid),
    .sample_stall     (sample_stall),
    .key_number       (key_number),
    .raw_byte         (raw_byte),
    .elapsed_ticks    (elapsed_ticks),
    .result_valid     (result_valid),
    .result_stall     (result_stall),
    .key_id           (key_id),
    .event_state      (event_state),
    .hold_ticks       (hold_ticks),
    .last_hold_ticks  (last_hold_ticks),
    .multi_click_hold (multi_click_hold)
  );

  // per key shadow of the block's store, zero as after the reset sweep
  event_t      key_ev      [256];
  logic [31:0] click_gap   [256];
  logic [31:0] hold_len    [256];
  logic [31:0] prev_hold   [256];
  logic        multi_flag  [256];
  logic [31:0] click_window = WINDOW_RESET;
  int unsigned event_tally [5];

  // traffic between the stimulus, the driver and the monitor
  key_sample_t pending_samples [$];
  key_result_t expected_results [$];
  key_sample_t cur_sample;
  key_result_t oldest_result;
  logic        key_down [256];    // press bit last queued per key, steers the random sequences
  logic [7:0]  hot_keys [4];

  int unsigned words_sent = 0;
  int unsigned words_checked = 0;
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;

  initial begin
    for (int i = 0; i < 256; i++) begin
      key_ev[i] = EV_NONE;
      click_gap[i] = '0;
      hold_len[i] = '0;
      prev_hold[i] = '0;
      multi_flag[i] = 1'b0;
      key_down[i] = 1'b0;
    end
    for (int i = 0; i < 5; i++) event_tally[i] = 0;
  end

  // timers add and stick at all ones
  function automatic logic [31:0] add_sat(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  // next event of one key; updates the shadow store as the block does
  function automatic key_result_t classify_sample(input key_sample_t s);
    key_result_t r;
    event_t      st;
    st = key_ev[s.key];
    click_gap[s.key] = add_sat(click_gap[s.key], {16'd0, s.dt});
    if (s.raw[PRESS_BIT]) begin
      if (st == EV_NONE || st == EV_UP) begin
        // a new press: multi click when close enough to the last one
        if (click_gap[s.key] <= click_window) begin
          st = EV_MULTI;
          multi_flag[s.key] = 1'b1;
        end else begin
          st = EV_DOWN;
          multi_flag[s.key] = 1'b0;
        end
        click_gap[s.key] = '0;
        hold_len[s.key] = '0;
      end else begin
        st = EV_PRESSED;
        hold_len[s.key] = add_sat(hold_len[s.key], {16'd0, s.dt});
      end
    end else if (st == EV_NONE || st == EV_UP) begin
      st = EV_NONE;
    end else begin
      // release latches the hold length
      st = EV_UP;
      prev_hold[s.key] = hold_len[s.key];
      hold_len[s.key] = '0;
    end
    key_ev[s.key] = st;
    event_tally[st]++;
    r.key_id = s.key;
    r.ev = st;
    r.hold = hold_len[s.key];
    r.last_hold = prev_hold[s.key];
    r.multi = multi_flag[s.key];
    return r;
  endfunction

  // sample driver: bursts of random length with random gaps between them
  always @(posedge clk) begin
    if (rst) begin
      sample_valid <= 1'b0;
    end else begin
      if (sample_valid && !sample_stall) begin
        expected_results.insert(expected_results.size(), classify_sample(cur_sample));
        words_sent++;
      end
      if (!sample_valid || !sample_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          sample_valid <= 1'b0;
        end else if (pending_samples.size() > 0) begin
          cur_sample = pending_samples.pop_front();
          key_number <= cur_sample.key;
          raw_byte <= cur_sample.raw;
          elapsed_ticks <= cur_sample.dt;
          sample_valid <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            // new burst; about a third of them follow without any gap
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          sample_valid <= 1'b0;
        end
      end
    end
  end

  // receiver stall: a pattern picked at random whenever stall_phase runs out, plus one long hold-off
  int unsigned stall_mode = 0;
  int unsigned stall_phase = 0;
  int unsigned hold_off_left = 0;
  logic        pressure_done = 1'b0;
  always @(posedge clk) begin
    if (stall_phase == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_phase = 50;
    end
    stall_phase--;
    if (!pressure_done && words_checked >= PRESSURE_AT) begin
      // sender keeps offering while results back up into the block
      hold_off_left = PRESSURE_CYCLES;
      pressure_done = 1'b1;
    end
    if (hold_off_left > 0) begin
      hold_off_left--;
      result_stall <= 1'b1;
    end else begin
      case (stall_mode)
        0: result_stall <= 1'b0;
        1: result_stall <= ($urandom_range(0, 3) == 0);
        2: result_stall <= ($urandom_range(0, 3) != 0);
        default: result_stall <= stall_phase[0];
      endcase
    end
  end

  // result monitor: every accepted word against the oldest expectation
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      if (expected_results.size() == 0) begin
        $error("result word for key %0d with nothing expected", key_id);
        mismatches++;
      end else begin
        oldest_result = expected_results.pop_front();
        if (key_id !== oldest_result.key_id) begin
          $error("key_id: expected %0d, got %0d", oldest_result.key_id, key_id);
          mismatches++;
        end
        if (event_state !== oldest_result.ev) begin
          $error("event_state: expected %0d, got %0d", oldest_result.ev, event_state);
          mismatches++;
        end
        if (hold_ticks !== oldest_result.hold) begin
          $error("hold_ticks: expected %0d, got %0d", oldest_result.hold, hold_ticks);
          mismatches++;
        end
        if (last_hold_ticks !== oldest_result.last_hold) begin
          $error("last_hold_ticks: expected %0d, got %0d",
                 oldest_result.last_hold, last_hold_ticks);
          mismatches++;
        end
        if (multi_click_hold !== oldest_result.multi) begin
          $error("multi_click_hold: expected %0d, got %0d", oldest_result.multi,
                 multi_click_hold);
          mismatches++;
        end
      end
      words_checked <= words_checked + 1;
    end
  end

  // hang guard
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > RUN_LIMIT) begin
      $display("timeout after %0d cycles, %0d words still expected", cycle_count,
               expected_results.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic push_sample(input logic [7:0] k, input logic [7:0] r, input logic [15:0] d);
    key_sample_t s;
    s.key = k;
    s.raw = r;
    s.dt = d;
    key_down[k] = r[PRESS_BIT];
    pending_samples.insert(pending_samples.size(), s);
  endtask

  // press / hold / release runs on a few busy keys, with stray keys mixed in
  task automatic push_random_samples(input int unsigned n);
    logic [7:0]  k;
    logic        press;
    logic [15:0] d;
    int unsigned sel;
    for (int i = 0; i < 4; i++) hot_keys[i] = 8'($urandom);
    for (int unsigned i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) < 7) k = hot_keys[$urandom_range(0, 3)];
      else k = 8'($urandom_range(0, 255));
      // held keys mostly stay held, so hold timers grow
      press = key_down[k] ? ($urandom_range(0, 9) < 7) : ($urandom_range(0, 9) < 5);
      sel = $urandom_range(0, 19);
      if (sel < 9) d = 16'($urandom_range(0, 100));
      else if (sel < 16) d = 16'($urandom_range(0, 700));
      else d = 16'($urandom_range(0, 65535));
      push_sample(k, {press, 7'($urandom)}, d);
    end
  endtask

  // wait until every queued word went through and every result came back
  task automatic drain();
    while (pending_samples.size() != 0 || sample_valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_window(input logic [31:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    click_window = v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // reset window: first press right after reset is a multi click, hold and release
    push_sample(8'd0, 8'h80, 16'd0);
    push_sample(8'd0, 8'hFF, 16'hFFFF);
    push_sample(8'd0, 8'h7F, 16'd1);
    push_sample(8'd0, 8'h00, 16'd0);
    // window edges: just over, exactly at, just over again
    push_sample(8'd1, 8'h80, 16'd300);
    push_sample(8'd1, 8'h00, 16'd0);
    push_sample(8'd1, 8'h80, 16'd250);
    push_sample(8'd1, 8'h00, 16'd0);
    push_sample(8'd1, 8'h80, 16'd251);
    push_sample(8'd1, 8'h81, 16'd5);
    // top key, zero-length hold, release while already released
    push_sample(8'd255, 8'hFE, 16'd251);
    push_sample(8'd255, 8'h80, 16'd0);
    push_sample(8'd255, 8'h01, 16'd0);
    push_sample(8'd255, 8'h7F, 16'hFFFF);
    push_sample(8'd0, 8'h80, 16'd0);
    push_sample(8'd170, 8'hAA, 16'hAAAA);
    push_sample(8'd85, 8'h55, 16'h5555);
    push_random_samples(200);
    drain();

    // zero window: only a press with no ticks since the last one is a multi click
    set_window(32'd0);
    push_sample(8'd2, 8'h80, 16'd0);
    push_sample(8'd2, 8'h00, 16'd0);
    push_sample(8'd2, 8'h80, 16'd0);
    push_sample(8'd2, 8'h00, 16'd1);
    push_sample(8'd2, 8'h80, 16'd0);
    push_random_samples(150);
    drain();

    set_window(32'hFFFF_FFFF);
    push_random_samples(150);
    drain();

    set_window(32'($urandom_range(1, 1000)));
    push_random_samples(250);
    drain();

    // one long hold carries the hold and gap timers well past 16 bits; the press after
    // it lies one tick outside the window
    set_window(32'(LONG_HOLD_SAMPLES * 65535 - 1));
    push_sample(8'd200, 8'h00, 16'd0);
    push_sample(8'd200, 8'h00, 16'd0);
    push_sample(8'd200, 8'h80, 16'd0);
    repeat (LONG_HOLD_SAMPLES) push_sample(8'd200, 8'hC3, 16'hFFFF);
    push_sample(8'd200, 8'h00, 16'd0);
    push_sample(8'd200, 8'h80, 16'd0);   // gap one tick past the window
    push_sample(8'd200, 8'h00, 16'd0);
    drain();

    $display("%0d sample words sent, %0d result words checked, window 250, 0, max and mid",
             words_sent, words_checked);
    $display("events: none %0d, down %0d, pressed %0d, up %0d, multi %0d; long hold done",
             event_tally[EV_NONE], event_tally[EV_DOWN], event_tally[EV_PRESSED],
             event_tally[EV_UP], event_tally[EV_MULTI]);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/kec_pkg.sv
rtl/core/key_event_classifier.sv
sim/tb_key_event_classifier.sv
